// ===== sv/assert_macros.svh =====
// assertion macros shared by the matcher modules
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define GWM_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// when pre holds, post holds at the next clock edge
`define GWM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/gwm_pkg.sv =====
// types, constants and helper functions of the glob wildcard matcher
// no dependencies
package gwm_pkg;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 5;
  localparam int CHARS_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_CHARS  = 16;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH     = 2'd0,
    CFG_PATTERN_CHARS_LOW  = 2'd1,
    CFG_PATTERN_CHARS_HIGH = 2'd2
  } cfg_idx_t;

  // handed from one position cell to the next in the same cycle
  typedef struct packed {
    logic en;        // this position lies inside the pattern
    logic cur_star;  // star closure of the current set
    logic nxt_step;  // advance into the next position on this character
    logic ncl_star;  // star closure of the next set
  } link_t;

  // ascii upper case folded to lower case
  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== sv/gwm_in_if.sv =====
// input channel of the matcher: one character or a terminator per item
// depends on gwm_pkg
interface gwm_in_if;
  logic                        valid;
  logic                        ready;
  logic [gwm_pkg::CHAR_W-1:0]  char_in;
  logic                        end_of_string;

  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

// ===== sv/gwm_out_if.sv =====
// result channel of the matcher: one match flag per terminator
// no dependencies
interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

// ===== sv/gwm_cfg.sv =====
// configuration registers and the derived per-position enables
// depends on gwm_pkg and assert_macros.svh
`include "assert_macros.svh"

module gwm_cfg #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [PATTERN_MAX-1:0]             pos_en,
  output logic [PATTERN_MAX-1:0][gwm_pkg::CHAR_W-1:0] pat_char
);

  logic [gwm_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [gwm_pkg::CHARS_W-1:0]      lo_r, lo_nxt;
  logic [gwm_pkg::CHARS_W-1:0]      hi_r, hi_nxt;
  logic [PATTERN_MAX-1:0]           en_r, en_nxt;
  logic [2*gwm_pkg::CHARS_W-1:0]    chars_nxt, chars_r;
  logic [PATTERN_MAX-1:0]           nz_nxt;

  always_comb begin
    len_nxt = len_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (cfg_we) begin
      case (cfg_index)
        gwm_pkg::CFG_PATTERN_LENGTH:     len_nxt = cfg_wdata[gwm_pkg::LEN_W-1:0];
        gwm_pkg::CFG_PATTERN_CHARS_LOW:  lo_nxt  = cfg_wdata;
        gwm_pkg::CFG_PATTERN_CHARS_HIGH: hi_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign chars_nxt = {hi_nxt, lo_nxt};
  assign chars_r   = {hi_r, lo_r};

  // a position is in use below the length and before the first zero byte
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    assign nz_nxt[i]   = chars_nxt[gwm_pkg::CHAR_W*i +: gwm_pkg::CHAR_W] != '0;
    assign en_nxt[i]   = (len_nxt > gwm_pkg::LEN_W'(i)) && (&nz_nxt[i:0]);
    assign pat_char[i] = chars_r[gwm_pkg::CHAR_W*i +: gwm_pkg::CHAR_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      lo_r  <= '0;
      hi_r  <= '0;
      en_r  <= '0;
    end else begin
      len_r <= len_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      en_r  <= en_nxt;
    end
  end

  assign pos_en = en_r;

  `GWM_ASSERT_ALWAYS(a_en_prefix, ((en_r + PATTERN_MAX'(1)) & en_r) == '0,
    "position enables are not a contiguous prefix")
  `GWM_ASSERT_NEXT(a_len_zero,
    cfg_we && (cfg_index == gwm_pkg::CFG_PATTERN_LENGTH)
      && (cfg_wdata[gwm_pkg::LEN_W-1:0] == '0),
    en_r == '0, "empty pattern left a position enabled")

endmodule

// ===== sv/gwm_cell.sv =====
// one pattern position: holds its active bit and passes star closure
// and character steps to the next position; depends on gwm_pkg
`include "assert_macros.svh"

module gwm_cell #(
  parameter bit START_POS = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        eos,
  input  logic [gwm_pkg::CHAR_W-1:0]  char_fold,
  input  logic [gwm_pkg::CHAR_W-1:0]  pat_char,
  input  logic                        pos_en,
  input  gwm_pkg::link_t              link_i,
  output gwm_pkg::link_t              link_o,
  output logic                        hit
);

  logic act_r, act_nxt;
  logic is_star, char_ok;
  logic cur, nxt, ncl;

  assign is_star = pat_char == gwm_pkg::STAR_CHAR;
  assign char_ok = (pat_char == gwm_pkg::ANY_CHAR) || (gwm_pkg::fold(pat_char) == char_fold);

  // stored bit only counts when the position before this one lies inside the pattern
  assign cur = (act_r & link_i.en) | link_i.cur_star;
  assign nxt = (cur & pos_en & is_star) | link_i.nxt_step;
  assign ncl = nxt | link_i.ncl_star;

  assign link_o.en       = pos_en;
  assign link_o.cur_star = cur & pos_en & is_star;
  assign link_o.nxt_step = cur & pos_en & !is_star & char_ok;
  assign link_o.ncl_star = ncl & pos_en & is_star;

  // current set reaches the end of the pattern here
  assign hit = cur & !pos_en;

  always_comb begin
    act_nxt = act_r;
    if (advance) begin
      act_nxt = eos ? START_POS : ncl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= START_POS;
    end else begin
      act_r <= act_nxt;
    end
  end

  `GWM_ASSERT_NEXT(a_restart, advance && eos, act_r == START_POS,
    "terminator did not restart the position")

endmodule

// ===== sv/glob_wildcard_matcher.sv =====
// Glob matcher top level: takes one item per clock, a character or a terminator, and
// returns one match flag per terminator in the cycle after the terminator is taken. A flag
// waiting in the output register holds off the input until the result side takes it; with
// the result side ready, items follow with no gap. The state update of a character is a
// single pass along the row of position cells, one per pattern character plus the end
// position, where star closure ripples from cell to cell. A configuration write is applied
// to the item taken on the following clock.
// depends on gwm_pkg, gwm_in_if, gwm_out_if, gwm_cfg, gwm_cell, assert_macros.svh
`include "assert_macros.svh"

module glob_wildcard_matcher #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gwm_in_if.sink                          in_ch,
  gwm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [PATTERN_MAX-1:0]                       pos_en;
  logic [PATTERN_MAX-1:0][gwm_pkg::CHAR_W-1:0]  pat_char;
  gwm_pkg::link_t                               lnk [PATTERN_MAX+2];
  logic [PATTERN_MAX:0]                         hits;
  logic [gwm_pkg::CHAR_W-1:0]                   char_fold;
  logic                                         in_acc, matched;
  logic                                         out_valid_r, out_valid_nxt;
  logic                                         out_matched_r;

  gwm_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pos_en    (pos_en),
    .pat_char  (pat_char)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign char_fold   = gwm_pkg::fold(in_ch.char_in);

  // start position is always inside the pattern
  assign lnk[0] = '{en: 1'b1, cur_star: 1'b0, nxt_step: 1'b0, ncl_star: 1'b0};

  for (genvar k = 0; k <= PATTERN_MAX; k++) begin : g_cell
    logic                       en_k;
    logic [gwm_pkg::CHAR_W-1:0] pc_k;
    if (k < PATTERN_MAX) begin : g_pat
      assign en_k = pos_en[k];
      assign pc_k = pat_char[k];
    end else begin : g_end
      assign en_k = 1'b0;
      assign pc_k = '0;
    end
    gwm_cell #(.START_POS(k == 0)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (in_acc),
      .eos       (in_ch.end_of_string),
      .char_fold (char_fold),
      .pat_char  (pc_k),
      .pos_en    (en_k),
      .link_i    (lnk[k]),
      .link_o    (lnk[k+1]),
      .hit       (hits[k])
    );
  end

  assign matched = |hits;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && in_ch.end_of_string) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.end_of_string) begin
      out_matched_r <= matched;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = out_matched_r;

  `GWM_ASSERT_NEXT(a_term_result, in_acc && in_ch.end_of_string,
    out_valid_r && (out_matched_r == $past(matched)),
    "terminator item did not produce its match flag")
  `GWM_ASSERT_NEXT(a_char_silent, in_acc && !in_ch.end_of_string && !out_valid_r,
    !out_valid_r, "character item produced a result")

endmodule

// ===== verif/tb_top.sv =====
// testbench for glob_wildcard_matcher: directed table, then random patterns and strings
// checked against an in-bench glob predictor, with random idling on both channels
// depends on gwm_pkg, gwm_in_if, gwm_out_if and the matcher rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int ITEM_TOTAL  = 1700;
  localparam int CALM_AFTER  = 1450;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 3;
  localparam logic [gwm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic                           wr;
    logic [gwm_pkg::CFG_IDX_W-1:0]  idx;
    logic [gwm_pkg::CFG_DATA_W-1:0] data;
    logic [gwm_pkg::CHAR_W-1:0]     chr;
    logic                           eos;
    logic                           typed;
    logic                           flag;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [gwm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gwm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic drv_typed;
  logic drv_flag;

  gwm_in_if  in_ch ();
  gwm_out_if out_ch ();

  glob_wildcard_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the pattern registers and the live position set
  logic [gwm_pkg::LEN_W-1:0]   pat_len;
  logic [gwm_pkg::CHARS_W-1:0] pat_lo;
  logic [gwm_pkg::CHARS_W-1:0] pat_hi;
  logic [16:0]                 live_set;

  bit flags_due[$];
  int mismatches;
  int sent_items;
  bit calm;
  bit hold_done;
  int gap_odds;
  plan_row_t plan[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [gwm_pkg::CHAR_W-1:0] lower_case(
      input logic [gwm_pkg::CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic [gwm_pkg::CHAR_W-1:0] pattern_byte(input int i);
    if (i < 8) begin
      return pat_lo[8*i +: 8];
    end
    if (i < 16) begin
      return pat_hi[8*(i-8) +: 8];
    end
    return 8'h00;
  endfunction

  // pattern stops at the first zero byte inside the configured length
  function automatic int usable_length();
    int n;
    n = (pat_len > gwm_pkg::MAX_CHARS) ? gwm_pkg::MAX_CHARS : int'(pat_len);
    for (int i = 0; i < n; i++) begin
      if (pattern_byte(i) == 8'h00) begin
        return i;
      end
    end
    return n;
  endfunction

  function automatic logic [16:0] star_closure(input logic [16:0] s, input int len);
    logic [17:0] span;
    span = (18'd1 << (len + 1)) - 18'd1;
    for (int i = 0; i < len; i++) begin
      if (s[i] && pattern_byte(i) == gwm_pkg::STAR_CHAR) begin
        s[i+1] = 1'b1;
      end
    end
    return s & span[16:0];
  endfunction

  task automatic advance_glob(input logic [gwm_pkg::CHAR_W-1:0] c, input logic eos,
                              output bit has_flag, output bit flag);
    int len;
    logic [17:0] span;
    logic [16:0] cur;
    logic [16:0] nxt;
    logic [gwm_pkg::CHAR_W-1:0] lc;
    logic [gwm_pkg::CHAR_W-1:0] p;
    len = usable_length();
    span = (18'd1 << (len + 1)) - 18'd1;
    cur = star_closure(live_set & span[16:0], len);
    lc = lower_case(c);
    nxt = '0;
    has_flag = 1'b0;
    flag = 1'b0;
    if (eos) begin
      has_flag = 1'b1;
      flag = cur[len];
      live_set = 17'd1;
    end else begin
      for (int i = 0; i < len; i++) begin
        if (cur[i]) begin
          p = pattern_byte(i);
          if (p == gwm_pkg::STAR_CHAR) begin
            nxt[i] = 1'b1;
          end else if (p == gwm_pkg::ANY_CHAR || lower_case(p) == lc) begin
            nxt[i+1] = 1'b1;
          end
        end
      end
      live_set = star_closure(nxt, len);
    end
  endtask

  // register writes, accepted items and returned flags, all seen at the rising edge
  always @(posedge clk) begin
    bit has_flag;
    bit flag;
    bit want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          gwm_pkg::CFG_PATTERN_LENGTH:     pat_len = cfg_wdata[gwm_pkg::LEN_W-1:0];
          gwm_pkg::CFG_PATTERN_CHARS_LOW:  pat_lo = cfg_wdata;
          gwm_pkg::CFG_PATTERN_CHARS_HIGH: pat_hi = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (flags_due.size() == 0) begin
          $error("matched: expected no item, actual %0b", out_ch.matched);
          mismatches++;
        end else begin
          want = flags_due.pop_front();
          if (out_ch.matched !== want) begin
            $error("matched: expected %0b, actual %0b", want, out_ch.matched);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_glob(in_ch.char_in, in_ch.end_of_string, has_flag, flag);
        if (has_flag) begin
          flags_due.push_back(drv_typed ? drv_flag : flag);
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  int quiet;
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random stalls, one long hold-off so the input backs up
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!hold_done && sent_items >= HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic [gwm_pkg::CHAR_W-1:0] c, input logic eos,
                           input logic typed, input logic flag);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_in       <= c;
    in_ch.end_of_string <= eos;
    drv_typed           <= typed;
    drv_flag            <= flag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
    if (sent_items >= CALM_AFTER) begin
      calm = 1'b1;
    end
    @(negedge clk);
  endtask

  // only once all flags are back and a character still in flight has settled
  task automatic write_reg(input logic [gwm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gwm_pkg::CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (flags_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [gwm_pkg::CHAR_W-1:0] edge_letter();
    logic [gwm_pkg::CHAR_W-1:0] picks[8];
    picks = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
    return picks[$urandom_range(0, 7)];
  endfunction

  function automatic logic [gwm_pkg::CHAR_W-1:0] pattern_symbol();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: return gwm_pkg::CHAR_W'(8'h61 + $urandom_range(0, 2));
      5:             return gwm_pkg::CHAR_W'(8'h41 + $urandom_range(0, 2));
      6, 7:          return gwm_pkg::STAR_CHAR;
      8:             return gwm_pkg::ANY_CHAR;
      9:             return gwm_pkg::CHAR_W'($urandom_range(1, 255));
      10:            return edge_letter();
      default:       return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'h63;
    endcase
  endfunction

  function automatic logic [gwm_pkg::CHAR_W-1:0] text_symbol();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return gwm_pkg::CHAR_W'(8'h61 + $urandom_range(0, 2));
      6:                return gwm_pkg::CHAR_W'(8'h41 + $urandom_range(0, 2));
      7:                return gwm_pkg::CHAR_W'($urandom_range(0, 255));
      8:                return edge_letter();
      default:          return ($urandom_range(0, 1) == 0) ? gwm_pkg::STAR_CHAR
                                                           : gwm_pkg::ANY_CHAR;
    endcase
  endfunction

  task automatic reprogram();
    int r;
    logic [gwm_pkg::CFG_DATA_W-1:0] len_word;
    logic [gwm_pkg::CFG_DATA_W-1:0] lo_word;
    logic [gwm_pkg::CFG_DATA_W-1:0] hi_word;
    r = $urandom_range(0, 9);
    len_word = {$urandom, $urandom};
    len_word[gwm_pkg::LEN_W-1:0] = (r < 6) ? gwm_pkg::LEN_W'($urandom_range(0, 5)) :
                                   (r < 9) ? gwm_pkg::LEN_W'($urandom_range(6, 16)) :
                                             gwm_pkg::LEN_W'($urandom_range(17, 31));
    for (int i = 0; i < 8; i++) begin
      lo_word[8*i +: 8] = pattern_symbol();
      hi_word[8*i +: 8] = pattern_symbol();
    end
    if ($urandom_range(0, 5) == 0) begin
      write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
    end
    if ($urandom_range(0, 1) == 0) begin
      write_reg(gwm_pkg::CFG_PATTERN_LENGTH, len_word);
    end
    if ($urandom_range(0, 4) != 0) begin
      write_reg(gwm_pkg::CFG_PATTERN_CHARS_LOW, lo_word);
    end
    if ($urandom_range(0, 2) != 0) begin
      write_reg(gwm_pkg::CFG_PATTERN_CHARS_HIGH, hi_word);
    end
    write_reg(gwm_pkg::CFG_PATTERN_LENGTH, len_word);
    case ($urandom_range(0, 2))
      0:       gap_odds = 0;
      1:       gap_odds = 3;
      default: gap_odds = 8;
    endcase
  endtask

  function automatic plan_row_t chr_row(input logic [gwm_pkg::CHAR_W-1:0] c);
    return '{1'b0, gwm_pkg::CFG_PATTERN_LENGTH, 64'd0, c, 1'b0, 1'b0, 1'b0};
  endfunction

  function automatic plan_row_t eos_row(input logic typed, input logic flag);
    return '{1'b0, gwm_pkg::CFG_PATTERN_LENGTH, 64'd0,
             gwm_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1, typed, flag};
  endfunction

  function automatic plan_row_t cfg_row(input logic [gwm_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [gwm_pkg::CFG_DATA_W-1:0] data);
    return '{1'b1, idx, data, 8'h00, 1'b0, 1'b0, 1'b0};
  endfunction

  initial begin
    logic [gwm_pkg::CHAR_W-1:0] text[$];
    logic [gwm_pkg::CHAR_W-1:0] p;
    int len;
    int split;
    int pos;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.char_in = '0;
    in_ch.end_of_string = 1'b0;
    drv_typed = 1'b0;
    drv_flag = 1'b0;
    pat_len = '0;
    pat_lo = '0;
    pat_hi = '0;
    live_set = 17'd1;
    mismatches = 0;
    sent_items = 0;
    calm = 1'b0;
    hold_done = 1'b0;
    gap_odds = 3;

    // empty pattern after reset, then a*?B, star run into a zero byte, all-ones pattern,
    // and a pattern swapped in the middle of a string
    plan = '{
      eos_row(1'b1, 1'b1),
      chr_row("a"), eos_row(1'b1, 1'b0),
      chr_row(8'h00), eos_row(1'b0, 1'b0),
      cfg_row(gwm_pkg::CFG_PATTERN_CHARS_LOW, 64'h0000_0000_423F_2A61),
      cfg_row(gwm_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE4),
      chr_row("A"), chr_row("x"), chr_row("q"), chr_row("b"), eos_row(1'b0, 1'b0),
      chr_row("a"), eos_row(1'b1, 1'b0),
      cfg_row(CFG_UNUSED_IDX, 64'd0),
      chr_row("a"), chr_row("Q"), chr_row("b"), eos_row(1'b0, 1'b0),
      cfg_row(gwm_pkg::CFG_PATTERN_CHARS_LOW, 64'h2A2A_2A2A_2A2A_2A2A),
      cfg_row(gwm_pkg::CFG_PATTERN_CHARS_HIGH, 64'h0000_0000_0000_3FFF),
      cfg_row(gwm_pkg::CFG_PATTERN_LENGTH, 64'd31),
      chr_row(8'h80), chr_row(8'hFF), chr_row(8'h00), eos_row(1'b0, 1'b0),
      chr_row(8'hFF), eos_row(1'b0, 1'b0),
      cfg_row(gwm_pkg::CFG_PATTERN_CHARS_LOW, 64'hFFFF_FFFF_FFFF_FFFF),
      cfg_row(gwm_pkg::CFG_PATTERN_CHARS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
      cfg_row(gwm_pkg::CFG_PATTERN_LENGTH, 64'd16),
      eos_row(1'b1, 1'b0),
      cfg_row(gwm_pkg::CFG_PATTERN_CHARS_LOW, 64'h0000_0000_0000_002A),
      cfg_row(gwm_pkg::CFG_PATTERN_LENGTH, 64'd1),
      chr_row("q"),
      cfg_row(gwm_pkg::CFG_PATTERN_CHARS_LOW, 64'h0000_0000_0000_003F),
      eos_row(1'b0, 1'b0)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[k]) begin
      if (plan[k].wr) begin
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_item(plan[k].chr, plan[k].eos, plan[k].typed, plan[k].flag);
      end
    end

    // mostly strings built to fit the pattern, some mutated, some pure noise
    while (sent_items < ITEM_TOTAL) begin
      if ($urandom_range(0, 11) == 0) begin
        reprogram();
      end
      text.delete();
      len = usable_length();
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(0, 8)) text.push_back(text_symbol());
      end else begin
        for (int i = 0; i < len; i++) begin
          p = pattern_byte(i);
          if (p == gwm_pkg::STAR_CHAR) begin
            repeat ($urandom_range(0, 3)) text.push_back(text_symbol());
          end else if (p == gwm_pkg::ANY_CHAR) begin
            text.push_back(text_symbol());
          end else begin
            // letters go out in either case
            if (p >= 8'h61 && p <= 8'h7A && $urandom_range(0, 1) == 0) begin
              p = p - 8'h20;
            end else if (p >= 8'h41 && p <= 8'h5A && $urandom_range(0, 1) == 0) begin
              p = p + 8'h20;
            end
            text.push_back(p);
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          pos = $urandom_range(0, text.size());
          case ($urandom_range(0, 2))
            0: text.insert(pos, text_symbol());
            1: if (text.size() > 0) text.delete(pos % text.size());
            default: if (text.size() > 0) text[pos % text.size()] = text_symbol();
          endcase
        end
      end
      split = ($urandom_range(0, 29) == 0) ? $urandom_range(0, text.size()) : -1;
      foreach (text[k]) begin
        if (k == split) begin
          reprogram();
        end
        send_item(text[k], 1'b0, 1'b0, 1'b0);
      end
      if (split == text.size()) begin
        reprogram();
      end
      send_item(gwm_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
    end

    in_ch.valid <= 1'b0;
    while (flags_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && flags_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/gwm_pkg.sv
sv/gwm_in_if.sv
sv/gwm_out_if.sv
sv/gwm_cfg.sv
sv/gwm_cell.sv
sv/glob_wildcard_matcher.sv
verif/tb_top.sv
